@@ rtl/thuv_pkg.sv @@
// ----------------------------------------------------------------------------
// thuv_pkg
// Shared constants and tables of the toroidal heading and unit vector unit.
// ----------------------------------------------------------------------------
package thuv_pkg;

    typedef enum logic {
        CMD_HEADING = 1'b0,
        CMD_POINTS  = 1'b1
    } t_cmd;

    typedef enum logic {
        CFG_MAP_WIDTH  = 1'b0,
        CFG_MAP_HEIGHT = 1'b1
    } t_cfg_idx;

    localparam int CFG_W       = 20;
    localparam int IN_COORD_W  = 20;
    localparam int ANGLE_IN_W  = 24;
    localparam int ANG_W       = 17;
    localparam int ANG_RAW_W   = 25;
    localparam int UNIT_W      = 16;
    localparam int QUOT_W      = 15;
    localparam int UNIT_FRAC   = 14;
    localparam int DIST_W      = 21;
    localparam int Z_W         = 27;

    localparam int DEG360      = 92160;
    localparam int DEG180      = 46080;
    localparam int DEG90       = 23040;
    localparam int DEG270      = 69120;
    localparam int ANG_OFFSET  = 92 * DEG360;
    localparam int UNIT_ONE    = 16384;
    localparam int GAIN_Q30    = 652032874;

    localparam logic [CFG_W-1:0] MAP_WIDTH_RST  = 20'd262144;
    localparam logic [CFG_W-1:0] MAP_HEIGHT_RST = 20'd196608;

    localparam int ATAN_TAB [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    function automatic logic [ANG_RAW_W-1:0] red_step(input logic [ANG_RAW_W-1:0] u,
                                                       input int k);
        logic [ANG_RAW_W-1:0] m;
        m = ANG_RAW_W'(DEG360 << k);
        return (u >= m) ? u - m : u;
    endfunction

endpackage

@@ rtl/thuv_front.sv @@
// ----------------------------------------------------------------------------
// thuv_front
// Displacement, torus folding, heading reduction and squared length.
// ----------------------------------------------------------------------------
module thuv_front #(
    parameter int P = 20
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic                                   i_cmd,
    input  logic signed [thuv_pkg::ANGLE_IN_W-1:0] i_angle,
    input  logic [thuv_pkg::IN_COORD_W-1:0]        i_from_x,
    input  logic [thuv_pkg::IN_COORD_W-1:0]        i_from_y,
    input  logic [thuv_pkg::IN_COORD_W-1:0]        i_to_x,
    input  logic [thuv_pkg::IN_COORD_W-1:0]        i_to_y,
    input  logic                                   i_wrap,
    input  logic [thuv_pkg::CFG_W-1:0]             i_map_w,
    input  logic [thuv_pkg::CFG_W-1:0]             i_map_h,
    output logic                                   o_valid,
    output logic                                   o_cmd,
    output logic [thuv_pkg::ANG_W-1:0]             o_angle,
    output logic signed [P+1:0]                    o_dx,
    output logic signed [P+1:0]                    o_dy,
    output logic [P:0]                             o_ax,
    output logic [P:0]                             o_ay,
    output logic [2*P+1:0]                         o_sq,
    output logic                                   o_zero
);
    localparam int DW = P + 2;
    localparam int SW = 2 * P + 2;
    localparam int RW = thuv_pkg::ANG_RAW_W;

    function automatic logic signed [DW-1:0] fold(input logic signed [DW-1:0] d,
                                                  input logic [P-1:0] span);
        logic signed [DW-1:0] hs;
        logic signed [DW-1:0] ws;
        hs = $signed({2'b00, span >> 1});
        ws = $signed({2'b00, span});
        if (d > hs) begin
            return d - ws;
        end else if (d < -hs) begin
            return d + ws;
        end
        return d;
    endfunction

    logic                                   r1_v;
    logic                                   r1_cmd;
    logic signed [thuv_pkg::ANGLE_IN_W-1:0] r1_ang;
    logic [P-1:0]                           r1_fx, r1_fy, r1_tx, r1_ty, r1_sw, r1_sh;
    logic                                   r1_wrap;

    logic                 r2_v, r2_cmd;
    logic [RW-1:0]        r2_u;
    logic signed [DW-1:0] r2_dx, r2_dy;
    logic [RW-1:0]        n2_u;
    logic signed [DW-1:0] n2_dx, n2_dy;

    logic                          r3_v, r3_cmd, r3_zero;
    logic [thuv_pkg::ANG_W-1:0]    r3_a;
    logic signed [DW-1:0]          r3_dx, r3_dy;
    logic [P:0]                    r3_ax, r3_ay;
    logic [SW-1:0]                 r3_sqx, r3_sqy;
    logic [RW-1:0]                 n3_u;
    logic [P:0]                    n3_ax, n3_ay;

    logic                          r4_v, r4_cmd, r4_zero;
    logic [thuv_pkg::ANG_W-1:0]    r4_a;
    logic signed [DW-1:0]          r4_dx, r4_dy;
    logic [P:0]                    r4_ax, r4_ay;
    logic [SW-1:0]                 r4_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_comb begin
        n2_u = RW'(int'(r1_ang) + thuv_pkg::ANG_OFFSET);
        for (int k = 7; k >= 4; k--) begin
            n2_u = thuv_pkg::red_step(n2_u, k);
        end
        n2_dx = $signed({2'b00, r1_tx}) - $signed({2'b00, r1_fx});
        n2_dy = $signed({2'b00, r1_ty}) - $signed({2'b00, r1_fy});
        if (r1_wrap) begin
            n2_dx = fold(n2_dx, r1_sw);
            n2_dy = fold(n2_dy, r1_sh);
        end
    end

    always_comb begin
        n3_u = r2_u;
        for (int k = 3; k >= 0; k--) begin
            n3_u = thuv_pkg::red_step(n3_u, k);
        end
        n3_ax = (P+1)'(r2_dx[DW-1] ? -r2_dx : r2_dx);
        n3_ay = (P+1)'(r2_dy[DW-1] ? -r2_dy : r2_dy);
    end

    always_ff @(posedge i_clk) begin
        r1_cmd  <= i_cmd;
        r1_ang  <= i_angle;
        r1_fx   <= P'(i_from_x);
        r1_fy   <= P'(i_from_y);
        r1_tx   <= P'(i_to_x);
        r1_ty   <= P'(i_to_y);
        r1_wrap <= i_wrap;
        r1_sw   <= P'(i_map_w);
        r1_sh   <= P'(i_map_h);

        r2_cmd  <= r1_cmd;
        r2_u    <= n2_u;
        r2_dx   <= n2_dx;
        r2_dy   <= n2_dy;

        r3_cmd  <= r2_cmd;
        r3_a    <= thuv_pkg::ANG_W'(n3_u);
        r3_dx   <= r2_dx;
        r3_dy   <= r2_dy;
        r3_ax   <= n3_ax;
        r3_ay   <= n3_ay;
        r3_sqx  <= SW'(n3_ax) * SW'(n3_ax);
        r3_sqy  <= SW'(n3_ay) * SW'(n3_ay);
        r3_zero <= (r2_dx == '0) && (r2_dy == '0);

        r4_cmd  <= r3_cmd;
        r4_a    <= r3_a;
        r4_dx   <= r3_dx;
        r4_dy   <= r3_dy;
        r4_ax   <= r3_ax;
        r4_ay   <= r3_ay;
        r4_sq   <= r3_sqx + r3_sqy;
        r4_zero <= r3_zero;
    end

    assign o_valid = r4_v;
    assign o_cmd   = r4_cmd;
    assign o_angle = r4_a;
    assign o_dx    = r4_dx;
    assign o_dy    = r4_dy;
    assign o_ax    = r4_ax;
    assign o_ay    = r4_ay;
    assign o_sq    = r4_sq;
    assign o_zero  = r4_zero;

endmodule

@@ rtl/thuv_sqrt.sv @@
// ----------------------------------------------------------------------------
// thuv_sqrt
// Pipelined restoring square root, one root bit per stage, rounded to nearest.
// ----------------------------------------------------------------------------
module thuv_sqrt #(
    parameter int P    = 20,
    parameter int SB_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [2*P+1:0]    i_sq,
    input  logic [SB_W-1:0]   i_sb,
    output logic              o_valid,
    output logic [P:0]        o_len,
    output logic [SB_W-1:0]   o_sb
);
    localparam int RB = P + 1;
    localparam int SW = 2 * P + 2;

    logic            r_v    [RB+1];
    logic [SW-1:0]   r_s    [RB+1];
    logic [RB+1:0]   r_rem  [RB+1];
    logic [RB-1:0]   r_root [RB+1];
    logic [SB_W-1:0] r_sb   [RB+1];

    logic            r_out_v;
    logic [RB-1:0]   r_len;
    logic [SB_W-1:0] r_out_sb;

    assign r_v[0]    = i_valid;
    assign r_s[0]    = i_sq;
    assign r_rem[0]  = '0;
    assign r_root[0] = '0;
    assign r_sb[0]   = i_sb;

    for (genvar k = 0; k < RB; k++) begin : g_stage
        logic [RB+1:0] rem_sh;
        logic [RB+1:0] trial;
        logic          ge;

        always_comb begin
            rem_sh = {r_rem[k][RB-1:0], r_s[k][SW-1-2*k -: 2]};
            trial  = {r_root[k], 2'b01};
            ge     = (rem_sh >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_s[k+1]    <= r_s[k];
            r_rem[k+1]  <= ge ? rem_sh - trial : rem_sh;
            r_root[k+1] <= {r_root[k][RB-2:0], ge};
            r_sb[k+1]   <= r_sb[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_v[RB];
        end
    end

    always_ff @(posedge i_clk) begin
        r_len    <= (r_rem[RB] > {2'b00, r_root[RB]}) ? r_root[RB] + 1'b1 : r_root[RB];
        r_out_sb <= r_sb[RB];
    end

    assign o_valid = r_out_v;
    assign o_len   = r_len;
    assign o_sb    = r_out_sb;

endmodule

@@ rtl/thuv_div.sv @@
// ----------------------------------------------------------------------------
// thuv_div
// Two-lane pipelined restoring divider for the unit vector components.
// ----------------------------------------------------------------------------
module thuv_div #(
    parameter int P    = 20,
    parameter int SB_W = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [P:0]                          i_ax,
    input  logic [P:0]                          i_ay,
    input  logic                                i_sx,
    input  logic                                i_sy,
    input  logic [P:0]                          i_len,
    input  logic [SB_W-1:0]                     i_sb,
    output logic                                o_valid,
    output logic signed [thuv_pkg::UNIT_W-1:0]  o_ux,
    output logic signed [thuv_pkg::UNIT_W-1:0]  o_uy,
    output logic [SB_W-1:0]                     o_sb
);
    localparam int RB = P + 1;
    localparam int NW = P + 16;
    localparam int QB = thuv_pkg::QUOT_W;
    localparam int UW = thuv_pkg::UNIT_W;

    logic            r_v   [QB+1];
    logic [NW-1:0]   r_rx  [QB+1];
    logic [NW-1:0]   r_ry  [QB+1];
    logic [QB-1:0]   r_qx  [QB+1];
    logic [QB-1:0]   r_qy  [QB+1];
    logic [RB-1:0]   r_len [QB+1];
    logic            r_sx  [QB+1];
    logic            r_sy  [QB+1];
    logic [SB_W-1:0] r_sb  [QB+1];

    logic                 r_out_v;
    logic signed [UW-1:0] r_ux, r_uy;
    logic [SB_W-1:0]      r_out_sb;

    function automatic logic signed [UW-1:0] finish(input logic [QB-1:0] q, input logic s);
        logic [QB-1:0]        qc;
        logic signed [UW-1:0] m;
        qc = (q > QB'(thuv_pkg::UNIT_ONE)) ? QB'(thuv_pkg::UNIT_ONE) : q;
        m  = $signed(UW'(qc));
        return s ? -m : m;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rx[0]  <= (NW'(i_ax) << thuv_pkg::UNIT_FRAC) + NW'(i_len >> 1);
        r_ry[0]  <= (NW'(i_ay) << thuv_pkg::UNIT_FRAC) + NW'(i_len >> 1);
        r_qx[0]  <= '0;
        r_qy[0]  <= '0;
        r_len[0] <= i_len;
        r_sx[0]  <= i_sx;
        r_sy[0]  <= i_sy;
        r_sb[0]  <= i_sb;
    end

    for (genvar t = 0; t < QB; t++) begin : g_stage
        logic [NW-1:0] dv;
        logic          gx, gy;

        always_comb begin
            dv = NW'(r_len[t]) << (QB - 1 - t);
            gx = (r_rx[t] >= dv);
            gy = (r_ry[t] >= dv);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[t+1] <= 1'b0;
            end else begin
                r_v[t+1] <= r_v[t];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rx[t+1]  <= gx ? r_rx[t] - dv : r_rx[t];
            r_ry[t+1]  <= gy ? r_ry[t] - dv : r_ry[t];
            r_qx[t+1]  <= {r_qx[t][QB-2:0], gx};
            r_qy[t+1]  <= {r_qy[t][QB-2:0], gy};
            r_len[t+1] <= r_len[t];
            r_sx[t+1]  <= r_sx[t];
            r_sy[t+1]  <= r_sy[t];
            r_sb[t+1]  <= r_sb[t];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_v[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ux     <= finish(r_qx[QB], r_sx[QB]);
        r_uy     <= finish(r_qy[QB], r_sy[QB]);
        r_out_sb <= r_sb[QB];
    end

    assign o_valid = r_out_v;
    assign o_ux    = r_ux;
    assign o_uy    = r_uy;
    assign o_sb    = r_out_sb;

endmodule

@@ rtl/thuv_cordic.sv @@
// ----------------------------------------------------------------------------
// thuv_cordic
// Unrolled CORDIC, rotation mode for headings and vectoring mode for points.
// ----------------------------------------------------------------------------
module thuv_cordic #(
    parameter int P    = 20,
    parameter int N    = 16,
    parameter int SB_W = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                i_cmd,
    input  logic [thuv_pkg::ANG_W-1:0]          i_angle,
    input  logic signed [P+1:0]                 i_dx,
    input  logic signed [P+1:0]                 i_dy,
    input  logic [SB_W-1:0]                     i_sb,
    output logic                                o_valid,
    output logic signed [thuv_pkg::UNIT_W-1:0]  o_ux,
    output logic signed [thuv_pkg::UNIT_W-1:0]  o_uy,
    output logic [thuv_pkg::ANG_W-1:0]          o_heading,
    output logic [SB_W-1:0]                     o_sb
);
    localparam int XW = (P + 11 > 33) ? P + 11 : 33;
    localparam int ZW = thuv_pkg::Z_W;
    localparam int UW = thuv_pkg::UNIT_W;
    localparam int AW = thuv_pkg::ANG_W;

    logic                 r_v   [N+1];
    logic                 r_rot [N+1];
    logic                 r_neg [N+1];
    logic signed [XW-1:0] r_x   [N+1];
    logic signed [XW-1:0] r_y   [N+1];
    logic signed [ZW-1:0] r_z   [N+1];
    logic [SB_W-1:0]      r_sb  [N+1];

    logic                 n_rot, n_neg;
    logic signed [XW-1:0] n_x, n_y;
    logic signed [ZW-1:0] n_z, az;

    logic                 r_out_v;
    logic signed [UW-1:0] r_ux, r_uy;
    logic [AW-1:0]        r_head;
    logic [SB_W-1:0]      r_out_sb;

    function automatic logic signed [UW-1:0] round_unit(input logic signed [XW-1:0] v,
                                                        input logic neg);
        logic signed [XW-1:0] r;
        logic signed [UW-1:0] m;
        r = (v + XW'(32768)) >>> 16;
        if (r > 16384) begin
            m = UW'(thuv_pkg::UNIT_ONE);
        end else if (r < -16384) begin
            m = -UW'(thuv_pkg::UNIT_ONE);
        end else begin
            m = UW'(r);
        end
        return neg ? -m : m;
    endfunction

    function automatic logic [AW-1:0] wrap_head(input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] h;
        h = (z + ZW'(128)) >>> 8;
        if (h < 0) begin
            h = h + ZW'(thuv_pkg::DEG360);
        end
        return AW'(h);
    endfunction

    always_comb begin
        az    = ZW'($signed({1'b0, i_angle}));
        n_rot = (i_cmd == thuv_pkg::CMD_HEADING);
        n_neg = 1'b0;
        n_x   = XW'(thuv_pkg::GAIN_Q30);
        n_y   = '0;
        if (n_rot) begin
            if (az >= ZW'(thuv_pkg::DEG90) && az < ZW'(thuv_pkg::DEG270)) begin
                n_z   = az - ZW'(thuv_pkg::DEG180);
                n_neg = 1'b1;
            end else if (az >= ZW'(thuv_pkg::DEG270)) begin
                n_z = az - ZW'(thuv_pkg::DEG360);
            end else begin
                n_z = az;
            end
            n_z = n_z <<< 8;
        end else begin
            n_x = XW'(i_dx) <<< 8;
            n_y = XW'(i_dy) <<< 8;
            n_z = '0;
            if (i_dx < 0) begin
                n_x = -n_x;
                n_y = -n_y;
                n_z = ZW'(thuv_pkg::DEG180) <<< 8;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rot[0] <= n_rot;
        r_neg[0] <= n_neg;
        r_x[0]   <= n_x;
        r_y[0]   <= n_y;
        r_z[0]   <= n_z;
        r_sb[0]  <= i_sb;
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic signed [XW-1:0] xs, ys;
        logic signed [ZW-1:0] at;
        logic                 ccw;

        always_comb begin
            xs  = r_x[i] >>> i;
            ys  = r_y[i] >>> i;
            at  = ZW'(thuv_pkg::ATAN_TAB[i]);
            ccw = r_rot[i] ? (r_z[i] >= 0) : !(r_y[i] > 0);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_x[i+1]   <= ccw ? r_x[i] - ys : r_x[i] + ys;
            r_y[i+1]   <= ccw ? r_y[i] + xs : r_y[i] - xs;
            r_z[i+1]   <= ccw ? r_z[i] - at : r_z[i] + at;
            r_rot[i+1] <= r_rot[i];
            r_neg[i+1] <= r_neg[i];
            r_sb[i+1]  <= r_sb[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ux     <= round_unit(r_x[N], r_neg[N]);
        r_uy     <= round_unit(r_y[N], r_neg[N]);
        r_head   <= wrap_head(r_z[N]);
        r_out_sb <= r_sb[N];
    end

    assign o_valid   = r_out_v;
    assign o_ux      = r_ux;
    assign o_uy      = r_uy;
    assign o_heading = r_head;
    assign o_sb      = r_out_sb;

endmodule

@@ rtl/toroidal_heading_unit_vector.sv @@
// ----------------------------------------------------------------------------
// toroidal_heading_unit_vector
// Heading to unit vector, and torus displacement to length, heading and unit.
// The front end, square root, divider and CORDIC stages run in series ahead of
// the output register; one beat per cycle.
// busy is always low and results are strobed on o_valid for one cycle.
// Synchronous reset clears all valid bits and loads the map registers.
// ----------------------------------------------------------------------------
module toroidal_heading_unit_vector #(
    parameter int COORD_BITS    = 20,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   i_cfg_we,
    input  logic                                   i_cfg_idx,
    input  logic [thuv_pkg::CFG_W-1:0]             i_cfg_data,
    input  logic                                   i_cmd,
    input  logic signed [thuv_pkg::ANGLE_IN_W-1:0] i_angle_in,
    input  logic [thuv_pkg::IN_COORD_W-1:0]        i_from_x,
    input  logic [thuv_pkg::IN_COORD_W-1:0]        i_from_y,
    input  logic [thuv_pkg::IN_COORD_W-1:0]        i_to_x,
    input  logic [thuv_pkg::IN_COORD_W-1:0]        i_to_y,
    input  logic                                   i_wrap_torus,
    output logic                                   o_valid,
    output logic signed [thuv_pkg::UNIT_W-1:0]     o_unit_x,
    output logic signed [thuv_pkg::UNIT_W-1:0]     o_unit_y,
    output logic [thuv_pkg::ANG_W-1:0]             o_heading,
    output logic [thuv_pkg::DIST_W-1:0]            o_distance,
    output logic                                   o_zero_length
);
    localparam int P  = COORD_BITS;
    localparam int DW = P + 2;
    localparam int AW = thuv_pkg::ANG_W;
    localparam int UW = thuv_pkg::UNIT_W;
    localparam int SQ_SB_W = 1 + AW + 2 * DW + 2 * (P + 1) + 1;
    localparam int DV_SB_W = 1 + AW + 2 * DW + 1 + (P + 1);
    localparam int CO_SB_W = 1 + AW + 1 + (P + 1) + 2 * UW;

    logic [thuv_pkg::CFG_W-1:0] r_map_w, r_map_h;

    logic                 f_v, f_cmd, f_zero;
    logic [AW-1:0]        f_a;
    logic signed [DW-1:0] f_dx, f_dy;
    logic [P:0]           f_ax, f_ay;
    logic [2*P+1:0]       f_sq;

    logic                 s_v;
    logic [P:0]           s_len;
    logic [SQ_SB_W-1:0]   s_sb;
    logic                 s_cmd, s_zero;
    logic [AW-1:0]        s_a;
    logic signed [DW-1:0] s_dx, s_dy;
    logic [P:0]           s_ax, s_ay;

    logic                 d_v;
    logic signed [UW-1:0] d_ux, d_uy;
    logic [DV_SB_W-1:0]   d_sb;
    logic                 d_cmd, d_zero;
    logic [AW-1:0]        d_a;
    logic signed [DW-1:0] d_dx, d_dy;
    logic [P:0]           d_len;

    logic                 c_v;
    logic signed [UW-1:0] c_ux, c_uy;
    logic [AW-1:0]        c_head;
    logic [CO_SB_W-1:0]   c_sb;
    logic                 c_cmd, c_zero;
    logic [AW-1:0]        c_a;
    logic [P:0]           c_len;
    logic signed [UW-1:0] c_dux, c_duy;

    logic                           r_out_v;
    logic signed [UW-1:0]           r_ux, r_uy;
    logic [AW-1:0]                  r_head;
    logic [thuv_pkg::DIST_W-1:0]    r_dist;
    logic                           r_zero;
    logic signed [UW-1:0]           n_ux, n_uy;
    logic [AW-1:0]                  n_head;
    logic [thuv_pkg::DIST_W-1:0]    n_dist;
    logic                           n_zero;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_w <= thuv_pkg::MAP_WIDTH_RST;
            r_map_h <= thuv_pkg::MAP_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                thuv_pkg::CFG_MAP_WIDTH:  r_map_w <= i_cfg_data;
                thuv_pkg::CFG_MAP_HEIGHT: r_map_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    thuv_front #(.P(P)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start && !busy),
        .i_cmd    (i_cmd),
        .i_angle  (i_angle_in),
        .i_from_x (i_from_x),
        .i_from_y (i_from_y),
        .i_to_x   (i_to_x),
        .i_to_y   (i_to_y),
        .i_wrap   (i_wrap_torus),
        .i_map_w  (r_map_w),
        .i_map_h  (r_map_h),
        .o_valid  (f_v),
        .o_cmd    (f_cmd),
        .o_angle  (f_a),
        .o_dx     (f_dx),
        .o_dy     (f_dy),
        .o_ax     (f_ax),
        .o_ay     (f_ay),
        .o_sq     (f_sq),
        .o_zero   (f_zero)
    );

    thuv_sqrt #(.P(P), .SB_W(SQ_SB_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_v),
        .i_sq    (f_sq),
        .i_sb    ({f_cmd, f_a, f_dx, f_dy, f_ax, f_ay, f_zero}),
        .o_valid (s_v),
        .o_len   (s_len),
        .o_sb    (s_sb)
    );

    assign {s_cmd, s_a, s_dx, s_dy, s_ax, s_ay, s_zero} = s_sb;

    thuv_div #(.P(P), .SB_W(DV_SB_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_v),
        .i_ax    (s_ax),
        .i_ay    (s_ay),
        .i_sx    (s_dx[DW-1]),
        .i_sy    (s_dy[DW-1]),
        .i_len   (s_len),
        .i_sb    ({s_cmd, s_a, s_dx, s_dy, s_zero, s_len}),
        .o_valid (d_v),
        .o_ux    (d_ux),
        .o_uy    (d_uy),
        .o_sb    (d_sb)
    );

    assign {d_cmd, d_a, d_dx, d_dy, d_zero, d_len} = d_sb;

    thuv_cordic #(.P(P), .N(CORDIC_STAGES), .SB_W(CO_SB_W)) u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (d_v),
        .i_cmd     (d_cmd),
        .i_angle   (d_a),
        .i_dx      (d_dx),
        .i_dy      (d_dy),
        .i_sb      ({d_cmd, d_a, d_zero, d_len, d_ux, d_uy}),
        .o_valid   (c_v),
        .o_ux      (c_ux),
        .o_uy      (c_uy),
        .o_heading (c_head),
        .o_sb      (c_sb)
    );

    assign {c_cmd, c_a, c_zero, c_len, c_dux, c_duy} = c_sb;

    always_comb begin
        n_ux   = '0;
        n_uy   = '0;
        n_head = '0;
        n_dist = '0;
        n_zero = 1'b0;
        if (c_cmd == thuv_pkg::CMD_HEADING) begin
            n_ux   = c_ux;
            n_uy   = c_uy;
            n_head = c_a;
        end else if (c_zero) begin
            n_zero = 1'b1;
        end else begin
            n_ux   = c_dux;
            n_uy   = c_duy;
            n_head = c_head;
            n_dist = thuv_pkg::DIST_W'(c_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ux   <= n_ux;
        r_uy   <= n_uy;
        r_head <= n_head;
        r_dist <= n_dist;
        r_zero <= n_zero;
    end

    assign o_valid       = r_out_v;
    assign o_unit_x      = r_ux;
    assign o_unit_y      = r_uy;
    assign o_heading     = r_head;
    assign o_distance    = r_dist;
    assign o_zero_length = r_zero;

endmodule

@@ sim/tb_toroidal_heading_unit_vector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_toroidal_heading_unit_vector
// Self-checking bench for the toroidal heading and unit vector unit. Headings
// and point pairs are sent in random bursts; each strobed beat is compared
// with a bit-accurate integer model of the CORDIC, square root and divider.
// ----------------------------------------------------------------------------
module tb_toroidal_heading_unit_vector;

    localparam int STAGES   = 16;
    localparam int LATENCY  = 62;
    localparam longint LIMIT = 2000000;

    typedef struct packed {
        logic signed [thuv_pkg::UNIT_W-1:0] ux;
        logic signed [thuv_pkg::UNIT_W-1:0] uy;
        logic [thuv_pkg::ANG_W-1:0]         hd;
        logic [thuv_pkg::DIST_W-1:0]        dlen;
        logic                               zero;
    } t_vec_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = 1'b0;
    logic [thuv_pkg::CFG_W-1:0] i_cfg_data = '0;
    logic i_cmd = 1'b0;
    logic signed [thuv_pkg::ANGLE_IN_W-1:0] i_angle_in = '0;
    logic [thuv_pkg::IN_COORD_W-1:0] i_from_x = '0, i_from_y = '0, i_to_x = '0, i_to_y = '0;
    logic i_wrap_torus = 1'b0;
    logic o_valid;
    logic signed [thuv_pkg::UNIT_W-1:0] o_unit_x, o_unit_y;
    logic [thuv_pkg::ANG_W-1:0] o_heading;
    logic [thuv_pkg::DIST_W-1:0] o_distance;
    logic o_zero_length;

    t_vec_res expected_q[$];
    longint map_w = 262144, map_h = 196608;
    int errors = 0, n_sent = 0, n_heading = 0, n_points = 0, n_zero = 0;
    longint cycles = 0;
    int burst_left = 0;

    toroidal_heading_unit_vector DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Timeout at %0t", $time);
            $display("FAIL");
            $finish;
        end
    end

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint fold_span(longint d, longint span);
        longint half = span >> 1;
        if (d > half) return d - span;
        if (d < -half) return d + span;
        return d;
    endfunction

    function automatic longint clamp_q14(longint v);
        if (v > 16384) return 16384;
        if (v < -16384) return -16384;
        return v;
    endfunction

    function automatic longint round_sqrt(longint s);
        longint r = 0, n = s, bit_v = 64'sd1 << 62;
        while (bit_v > n) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (n >= r + bit_v) begin
                n = n - (r + bit_v);
                r = (r >> 1) + bit_v;
            end else begin
                r = r >> 1;
            end
            bit_v = bit_v >> 2;
        end
        if (s - r * r > r) r++;
        return r;
    endfunction

    function automatic longint q14_div(longint d, longint len);
        longint mag = (d < 0 ? -d : d) << 14;
        longint q = (mag + len / 2) / len;
        return clamp_q14(d < 0 ? -q : q);
    endfunction

    function automatic t_vec_res predict_vector(thuv_pkg::t_cmd cmd,
            logic signed [23:0] ang, longint fx, longint fy, longint tx, longint ty,
            logic wrap);
        t_vec_res r;
        longint ux = 0, uy = 0, hd = 0, dlen = 0, zero = 0;
        longint a, z, x, y, xs, ys, dx, dy;
        bit neg = 0;
        if (cmd == thuv_pkg::CMD_HEADING) begin
            a = ang;
            a = a % thuv_pkg::DEG360;
            if (a < 0) a += thuv_pkg::DEG360;
            hd = a;
            if (a >= thuv_pkg::DEG90 && a < thuv_pkg::DEG270) begin
                z = a - thuv_pkg::DEG180;
                neg = 1;
            end else if (a >= thuv_pkg::DEG270) begin
                z = a - thuv_pkg::DEG360;
            end else begin
                z = a;
            end
            z = z * 256;
            x = thuv_pkg::GAIN_Q30;
            y = 0;
            for (int i = 0; i < STAGES; i++) begin
                xs = fshift(x, i);
                ys = fshift(y, i);
                if (z >= 0) begin
                    x -= ys; y += xs; z -= thuv_pkg::ATAN_TAB[i];
                end else begin
                    x += ys; y -= xs; z += thuv_pkg::ATAN_TAB[i];
                end
            end
            ux = clamp_q14(fshift(x + 32768, 16));
            uy = clamp_q14(fshift(y + 32768, 16));
            if (neg) begin
                ux = -ux;
                uy = -uy;
            end
        end else begin
            dx = tx - fx;
            dy = ty - fy;
            if (wrap) begin
                dx = fold_span(dx, map_w);
                dy = fold_span(dy, map_h);
            end
            if (dx == 0 && dy == 0) begin
                zero = 1;
            end else begin
                dlen = round_sqrt(dx * dx + dy * dy);
                ux = q14_div(dx, dlen);
                uy = q14_div(dy, dlen);
                x = dx * 256;
                y = dy * 256;
                z = 0;
                if (x < 0) begin
                    x = -x;
                    y = -y;
                    z = longint'(thuv_pkg::DEG180) * 256;
                end
                for (int i = 0; i < STAGES; i++) begin
                    xs = fshift(x, i);
                    ys = fshift(y, i);
                    if (y > 0) begin
                        x += ys; y -= xs; z += thuv_pkg::ATAN_TAB[i];
                    end else begin
                        x -= ys; y += xs; z -= thuv_pkg::ATAN_TAB[i];
                    end
                end
                hd = fshift(z + 128, 8) % thuv_pkg::DEG360;
                if (hd < 0) hd += thuv_pkg::DEG360;
            end
        end
        r.ux = ux[15:0];
        r.uy = uy[15:0];
        r.hd = hd[16:0];
        r.dlen = dlen[20:0];
        r.zero = zero[0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_vec_res e;
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected beat", $time);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (o_unit_x !== e.ux) begin
                    $display("%0t: unit_x exp %0d got %0d", $time, e.ux, o_unit_x);
                    errors++;
                end
                if (o_unit_y !== e.uy) begin
                    $display("%0t: unit_y exp %0d got %0d", $time, e.uy, o_unit_y);
                    errors++;
                end
                if (o_heading !== e.hd) begin
                    $display("%0t: heading exp %0d got %0d", $time, e.hd, o_heading);
                    errors++;
                end
                if (o_distance !== e.dlen) begin
                    $display("%0t: distance exp %0d got %0d", $time, e.dlen, o_distance);
                    errors++;
                end
                if (o_zero_length !== e.zero) begin
                    $display("%0t: zero_length exp %0d got %0d", $time, e.zero,
                             o_zero_length);
                    errors++;
                end
            end
        end
    end

    // Sends one beat, with random gaps between bursts.
    task automatic send_item(thuv_pkg::t_cmd cmd, logic [23:0] ang, logic [19:0] fx,
            logic [19:0] fy, logic [19:0] tx, logic [19:0] ty, logic wrap);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        i_cmd <= cmd;
        i_angle_in <= ang;
        i_from_x <= fx;
        i_from_y <= fy;
        i_to_x <= tx;
        i_to_y <= ty;
        i_wrap_torus <= wrap;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_q.push_back(predict_vector(cmd, ang, fx, fy, tx, ty, wrap));
        n_sent++;
        if (cmd == thuv_pkg::CMD_HEADING) n_heading++; else n_points++;
        if (cmd == thuv_pkg::CMD_POINTS && tx - fx == 0 && ty - fy == 0) n_zero++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        burst_left = 0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic write_map(thuv_pkg::t_cfg_idx idx, logic [19:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == thuv_pkg::CFG_MAP_WIDTH) map_w = val; else map_h = val;
        @(negedge i_clk);
    endtask

    task automatic test_directed_headings();
        send_item(thuv_pkg::CMD_HEADING, 24'h000000, 0, 0, 0, 0, 0);
        send_item(thuv_pkg::CMD_HEADING, 24'h7FFFFF, '1, '1, '1, '1, 1);
        send_item(thuv_pkg::CMD_HEADING, 24'h800000, 0, 0, 0, 0, 0);
        send_item(thuv_pkg::CMD_HEADING, 24'(thuv_pkg::DEG90), 0, 0, 0, 0, 0);
        send_item(thuv_pkg::CMD_HEADING, 24'(thuv_pkg::DEG180), 0, 0, 0, 0, 0);
        send_item(thuv_pkg::CMD_HEADING, 24'(thuv_pkg::DEG270), 0, 0, 0, 0, 0);
        send_item(thuv_pkg::CMD_HEADING, 24'(thuv_pkg::DEG360), 0, 0, 0, 0, 0);
        send_item(thuv_pkg::CMD_HEADING, -24'sd1, 0, 0, 0, 0, 0);
        send_item(thuv_pkg::CMD_HEADING, -24'(thuv_pkg::DEG90), 0, 0, 0, 0, 0);
    endtask

    task automatic test_directed_points();
        send_item(thuv_pkg::CMD_POINTS, 0, 100, 100, 100, 100, 0);
        send_item(thuv_pkg::CMD_POINTS, 0, 0, 0, 0, 0, 1);
        send_item(thuv_pkg::CMD_POINTS, 0, 0, 0, '1, '1, 0);
        send_item(thuv_pkg::CMD_POINTS, 0, '1, '1, 0, 0, 0);
        send_item(thuv_pkg::CMD_POINTS, 0, 0, 0, '1, '1, 1);
        send_item(thuv_pkg::CMD_POINTS, 0, 0, 0, 131072, 98304, 1);
        send_item(thuv_pkg::CMD_POINTS, 0, 0, 0, 131073, 98305, 1);
        send_item(thuv_pkg::CMD_POINTS, 0, 131073, 98305, 0, 0, 1);
        send_item(thuv_pkg::CMD_POINTS, 0, 0, 0, 256, 0, 0);
        send_item(thuv_pkg::CMD_POINTS, 0, 0, 0, 0, 256, 0);
        send_item(thuv_pkg::CMD_POINTS, 0, 256, 0, 0, 0, 0);
        send_item(thuv_pkg::CMD_POINTS, 0, 0, 256, 0, 0, 0);
        send_item(thuv_pkg::CMD_POINTS, 0, 0, 0, 1, 1, 0);
    endtask

    task automatic random_item(int wide);
        logic [19:0] fx, fy, tx, ty;
        fx = $urandom;
        fy = $urandom;
        if (wide || $urandom_range(0, 1)) begin
            tx = $urandom;
            ty = $urandom;
        end else begin
            tx = fx + 20'($urandom_range(0, 2000)) - 20'd1000;
            ty = fy + 20'($urandom_range(0, 2000)) - 20'd1000;
        end
        if ($urandom_range(0, 40) == 0) begin
            tx = fx;
            ty = fy;
        end
        if ($urandom_range(0, 2) == 0)
            send_item(thuv_pkg::CMD_HEADING, 24'($urandom), fx, fy, tx, ty, 1'($urandom));
        else
            send_item(thuv_pkg::CMD_POINTS, 24'($urandom), fx, fy, tx, ty, 1'($urandom));
    endtask

    task automatic test_random_phase(logic [19:0] w, logic [19:0] h, int count);
        drain();
        write_map(thuv_pkg::CFG_MAP_WIDTH, w);
        write_map(thuv_pkg::CFG_MAP_HEIGHT, h);
        for (int k = 0; k < count; k++) random_item(k % 2);
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_headings();
        test_directed_points();
        test_random_phase(20'd262144, 20'd196608, 450);
        test_random_phase(20'd1, 20'd1, 300);
        test_random_phase(20'hFFFFF, 20'hFFFFF, 350);
        test_random_phase(20'd0, 20'd0, 250);
        test_random_phase(20'($urandom), 20'($urandom), 480);
        drain();
        $display("Sent %0d beats: %0d headings, %0d point pairs, %0d coincident.",
                 n_sent, n_heading, n_points, n_zero);
        $display("Map sizes covered reset, one, zero, full scale and random values.");
        if (errors == 0 && expected_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

@@ sim.f @@
rtl/thuv_pkg.sv
rtl/thuv_front.sv
rtl/thuv_sqrt.sv
rtl/thuv_div.sv
rtl/thuv_cordic.sv
rtl/toroidal_heading_unit_vector.sv
sim/tb_toroidal_heading_unit_vector.sv
